### hdl/tach_pkg.sv
// Shared types and constants for the rolling-average tachometer.
// Used by tach_ctrl, tach_dp, the top level and the checker; no dependencies.
`default_nettype none

package tach_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_DEF      = 8;
  localparam int PERIOD_BITS_DEF = 40;

  // Tenths of an RPM times nanoseconds per minute: 600e9 fits in 40 bits.
  localparam int             TENTHS_W          = 40;
  localparam logic [39:0]    TENTHS_NS_PER_MIN = 40'd600000000000;
  localparam logic [23:0]    RPM_MAX           = 24'hFFFFFF;

  // Configuration register indexes.
  localparam logic CFG_PULSES_PER_REV = 1'b0;
  localparam logic CFG_DEBOUNCE_US    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0]  PPR_RESET      = 8'd1;
  localparam logic [19:0] DEBOUNCE_RESET = 20'd1000;

  // Result status codes.
  localparam logic [2:0] STAT_REFERENCE   = 3'd0;
  localparam logic [2:0] STAT_DEBOUNCED   = 3'd1;
  localparam logic [2:0] STAT_UPDATED     = 3'd2;
  localparam logic [2:0] STAT_TIMEOUT_CLR = 3'd3;
  localparam logic [2:0] STAT_TIMEOUT_IGN = 3'd4;

  // Event codes on the input op field.
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_POST
  } tach_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic sum_step;
    logic prep;
    logic div_step;
    logic publish;
  } tach_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic update;
    logic sum_done;
    logic div_needed;
    logic div_last;
    logic out_free;
  } tach_stat_t;

endpackage

`default_nettype wire

### hdl/tachometer_rolling_rpm_unit.sv
// Rolling-average tachometer: one sensor event word in, one speed/status word out.
// Channel: in_op, in_edge_time_ns under in_valid/in_stall.
// Result:  out_rpm_tenths, out_status under out_valid/out_stall.
// Config:  cfg_wr_en writes cfg_wdata to register cfg_index
//          (0 pulses per revolution, 1 debounce time in microseconds).
// One event word is worked on at a time; in_stall is high from acceptance
// until its result has been placed in the output register.
// Timeouts, reference edges and debounced edges go from evaluation straight to
// publishing. An accepted period also passes through the ring sum, the prepare
// step and, unless the reading saturates or is zero, N = 40 + clog2(WINDOW + 1)
// restoring divider steps.
// The ring sum reads one stored period per cycle from the ring memory.
// A finished result sits in the output register while the receiver stalls, and
// the next event word is accepted meanwhile; a second result waits until the
// output register is taken.
// Synchronous active-low reset clears the reading, the reference and the
// period count and loads 1 pulse per revolution and 1000 us debounce.
`default_nettype none

module tachometer_rolling_rpm_unit #(
  parameter int WINDOW      = tach_pkg::WINDOW_DEF,
  parameter int PERIOD_BITS = tach_pkg::PERIOD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [19:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [63:0] in_edge_time_ns,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_rpm_tenths,
  output logic [2:0]       out_status
);

  tach_pkg::tach_cmd_t  cmd;
  tach_pkg::tach_stat_t stat;

  tach_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tach_dp #(
    .WINDOW      (WINDOW),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_op),
    .in_edge_time_ns (in_edge_time_ns),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rpm_tenths  (out_rpm_tenths),
    .out_status      (out_status),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

`default_nettype wire

### hdl/tach_ctrl.sv
// Tachometer sequencer: steps one word through evaluate, ring sum, prepare,
// divide and publish. Depends on tach_pkg for the state, command and status types.
`default_nettype none

module tach_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tach_pkg::tach_stat_t stat,
  output tach_pkg::tach_cmd_t     cmd
);

  tach_pkg::tach_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tach_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tach_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tach_pkg::ST_EVAL;
      end
      tach_pkg::ST_EVAL: begin
        state_nxt = stat.update ? tach_pkg::ST_SUM : tach_pkg::ST_POST;
      end
      tach_pkg::ST_SUM: begin
        if (stat.sum_done) state_nxt = tach_pkg::ST_PREP;
      end
      tach_pkg::ST_PREP: begin
        state_nxt = stat.div_needed ? tach_pkg::ST_DIV : tach_pkg::ST_POST;
      end
      tach_pkg::ST_DIV: begin
        if (stat.div_last) state_nxt = tach_pkg::ST_POST;
      end
      tach_pkg::ST_POST: begin
        if (stat.out_free) state_nxt = tach_pkg::ST_IDLE;
      end
      default: state_nxt = tach_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      tach_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tach_pkg::ST_EVAL: cmd.eval     = 1'b1;
      tach_pkg::ST_SUM:  cmd.sum_step = 1'b1;
      tach_pkg::ST_PREP: cmd.prep     = 1'b1;
      tach_pkg::ST_DIV:  cmd.div_step = 1'b1;
      tach_pkg::ST_POST: cmd.publish  = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/tach_dp.sv
// Datapath of the tachometer: config registers, period ring memory, saturating
// sum, restoring divider and output register. Depends on tach_pkg.
`default_nettype none

module tach_dp #(
  parameter int WINDOW      = tach_pkg::WINDOW_DEF,
  parameter int PERIOD_BITS = tach_pkg::PERIOD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_index,
  input  wire logic [19:0]        cfg_wdata,
  input  wire logic               in_op,
  input  wire logic [63:0]        in_edge_time_ns,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [23:0]             out_rpm_tenths,
  output logic [2:0]              out_status,
  input  wire tach_pkg::tach_cmd_t cmd,
  output tach_pkg::tach_stat_t    stat
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int NUM_W  = tach_pkg::TENTHS_W + CNT_W;
  localparam int DEN_W  = NUM_W + 8;
  localparam int DCNT_W = $clog2(NUM_W);

  // Configuration.
  logic [7:0]  ppr_r, ppr_nxt;
  logic [19:0] deb_r, deb_nxt;

  // Event state.
  logic                   op_r, op_nxt;
  logic [63:0]            time_r, time_nxt;
  logic [63:0]            last_r, last_nxt;
  logic                   have_ref_r, have_ref_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [63:0]            sum_r, sum_nxt;
  logic [23:0]            reading_r, reading_nxt;
  logic [2:0]             stat_r, stat_nxt;

  // Ring scan.
  logic [CNT_W-1:0]       sidx_r, sidx_nxt;
  logic                   pend_r, pend_nxt;
  logic [PERIOD_BITS-1:0] rd_data_r;
  logic                   rd_en;
  logic                   ring_we;
  logic [PERIOD_BITS-1:0] ring_mem [WINDOW];

  // Divider.
  logic [DEN_W-1:0]       den_r, den_nxt;
  logic [DEN_W-1:0]       rem_r, rem_nxt;
  logic [NUM_W-1:0]       quo_r, quo_nxt;
  logic [DCNT_W-1:0]      dcnt_r, dcnt_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [23:0]            out_rpm_r, out_rpm_nxt;
  logic [2:0]             out_status_r, out_status_nxt;

  // Combinational helpers.
  logic [63:0]            delta;
  logic [29:0]            deb_ns;
  logic                   debounced;
  logic [PERIOD_BITS-1:0] period_w;
  logic [64:0]            acc;
  logic [NUM_W-1:0]       num_w;
  logic [DEN_W-1:0]       den_w;
  logic                   zero_den;
  logic                   too_big;
  logic [DEN_W:0]         shifted;
  logic [DEN_W:0]         diff;
  logic                   ge;
  logic [NUM_W-1:0]       quo_step;
  logic [23:0]            quo_sat;

  assign delta     = time_r - last_r;
  assign deb_ns    = {10'd0, deb_r} * 30'd1000;
  assign debounced = delta < {34'd0, deb_ns};

  if (PERIOD_BITS < 64) begin : g_cap
    assign period_w = (|delta[63:PERIOD_BITS]) ? '1 : delta[PERIOD_BITS-1:0];
  end else begin : g_nocap
    assign period_w = delta[PERIOD_BITS-1:0];
  end

  assign acc = {1'b0, sum_r} + {{(65 - PERIOD_BITS){1'b0}}, rd_data_r};

  assign num_w    = {{CNT_W{1'b0}}, tach_pkg::TENTHS_NS_PER_MIN} *
                    {{tach_pkg::TENTHS_W{1'b0}}, count_r};
  assign zero_den = (sum_r == 64'd0) || (ppr_r == 8'd0);
  assign too_big  = sum_r > {{(64 - NUM_W){1'b0}}, num_w};
  assign den_w    = {8'd0, sum_r[NUM_W-1:0]} * {{NUM_W{1'b0}}, ppr_r};

  assign shifted  = {rem_r, quo_r[NUM_W-1]};
  assign ge       = shifted >= {1'b0, den_r};
  assign diff     = shifted - {1'b0, den_r};
  assign quo_step = {quo_r[NUM_W-2:0], ge};
  assign quo_sat  = (|quo_step[NUM_W-1:24]) ? tach_pkg::RPM_MAX : quo_step[23:0];

  assign stat.update     = (op_r == tach_pkg::OP_EDGE) && have_ref_r && !debounced;
  assign stat.sum_done   = (sidx_r == count_r) && !pend_r;
  assign stat.div_needed = !zero_den && !too_big;
  assign stat.div_last   = dcnt_r == DCNT_W'(NUM_W - 1);
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign rd_en   = cmd.sum_step && (sidx_r < count_r);
  assign ring_we = cmd.eval && stat.update;

  always_comb begin
    ppr_nxt        = ppr_r;
    deb_nxt        = deb_r;
    op_nxt         = op_r;
    time_nxt       = time_r;
    last_nxt       = last_r;
    have_ref_nxt   = have_ref_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    sum_nxt        = sum_r;
    reading_nxt    = reading_r;
    stat_nxt       = stat_r;
    sidx_nxt       = sidx_r;
    pend_nxt       = pend_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dcnt_nxt       = dcnt_r;
    out_valid_nxt  = out_valid_r;
    out_rpm_nxt    = out_rpm_r;
    out_status_nxt = out_status_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        tach_pkg::CFG_PULSES_PER_REV: ppr_nxt = cfg_wdata[7:0];
        tach_pkg::CFG_DEBOUNCE_US:    deb_nxt = cfg_wdata;
        default: begin
          ppr_nxt = ppr_r;
        end
      endcase
    end

    if (cmd.load) begin
      op_nxt   = in_op;
      time_nxt = in_edge_time_ns;
    end

    if (cmd.eval) begin
      if (op_r == tach_pkg::OP_TIMEOUT) begin
        if (have_ref_r) begin
          reading_nxt  = '0;
          count_nxt    = '0;
          slot_nxt     = '0;
          sum_nxt      = '0;
          have_ref_nxt = 1'b0;
          stat_nxt     = tach_pkg::STAT_TIMEOUT_CLR;
        end else begin
          stat_nxt = tach_pkg::STAT_TIMEOUT_IGN;
        end
      end else if (!have_ref_r) begin
        last_nxt     = time_r;
        have_ref_nxt = 1'b1;
        stat_nxt     = tach_pkg::STAT_REFERENCE;
      end else if (debounced) begin
        stat_nxt = tach_pkg::STAT_DEBOUNCED;
      end else begin
        slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
        if (count_r < CNT_W'(WINDOW)) count_nxt = count_r + 1'b1;
        last_nxt = time_r;
        stat_nxt = tach_pkg::STAT_UPDATED;
        sum_nxt  = '0;
        sidx_nxt = '0;
        pend_nxt = 1'b0;
      end
    end

    // Reads are issued one per cycle; the read data is registered and added in the next cycle.
    if (cmd.sum_step) begin
      if (pend_r) sum_nxt = acc[64] ? '1 : acc[63:0];
      if (rd_en) begin
        sidx_nxt = sidx_r + 1'b1;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
    end

    if (cmd.prep) begin
      if (zero_den) begin
        reading_nxt = tach_pkg::RPM_MAX;
      end else if (too_big) begin
        reading_nxt = '0;
      end else begin
        den_nxt  = den_w;
        rem_nxt  = '0;
        quo_nxt  = num_w;
        dcnt_nxt = '0;
      end
    end

    if (cmd.div_step) begin
      rem_nxt  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt  = quo_step;
      dcnt_nxt = dcnt_r + 1'b1;
      if (stat.div_last) reading_nxt = quo_sat;
    end

    if (cmd.publish) begin
      out_valid_nxt  = 1'b1;
      out_rpm_nxt    = reading_r;
      out_status_nxt = stat_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r       <= tach_pkg::PPR_RESET;
      deb_r       <= tach_pkg::DEBOUNCE_RESET;
      last_r      <= '0;
      have_ref_r  <= 1'b0;
      count_r     <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      reading_r   <= '0;
      sidx_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ppr_r       <= ppr_nxt;
      deb_r       <= deb_nxt;
      last_r      <= last_nxt;
      have_ref_r  <= have_ref_nxt;
      count_r     <= count_nxt;
      slot_r      <= slot_nxt;
      sum_r       <= sum_nxt;
      reading_r   <= reading_nxt;
      sidx_r      <= sidx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    time_r       <= time_nxt;
    stat_r       <= stat_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dcnt_r       <= dcnt_nxt;
    out_rpm_r    <= out_rpm_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[slot_r] <= period_w;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= ring_mem[sidx_r[SLOT_W-1:0]];
  end

  assign out_valid      = out_valid_r;
  assign out_rpm_tenths = out_rpm_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

### hdl/tach_chk.sv
// Port-level checks for the tachometer, bound to the top level.
// Depends on tach_pkg for the status codes.
`default_nettype none

module tach_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_rpm_tenths,
  input wire logic [2:0]  out_status
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rpm_tenths) && $stable(out_status))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == tach_pkg::STAT_REFERENCE ||
                   out_status == tach_pkg::STAT_DEBOUNCED ||
                   out_status == tach_pkg::STAT_UPDATED ||
                   out_status == tach_pkg::STAT_TIMEOUT_CLR ||
                   out_status == tach_pkg::STAT_TIMEOUT_IGN))
    else $error("undefined status code");

  // Without a reference no periods are stored, so the reading must be zero.
  a_no_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tach_pkg::STAT_REFERENCE ||
                  out_status == tach_pkg::STAT_TIMEOUT_CLR ||
                  out_status == tach_pkg::STAT_TIMEOUT_IGN) |-> out_rpm_tenths == 24'd0)
    else $error("nonzero reading without a reference");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tachometer_rolling_rpm_unit tach_chk u_tach_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_rpm_tenths (out_rpm_tenths),
  .out_status     (out_status)
);

`default_nettype wire

### tb/tb_tachometer_rolling_rpm_unit.sv
// Self-checking bench for tachometer_rolling_rpm_unit: predicts the averaged speed
// and status of every accepted sensor event word and checks each result word.
// Depends on tach_pkg and the RTL top level only.

module tb_tachometer_rolling_rpm_unit;

  localparam int WIN = tach_pkg::WINDOW_DEF;
  localparam int PBITS = tach_pkg::PERIOD_BITS_DEF;
  localparam logic [63:0] PERIOD_CAP = (64'd1 << PBITS) - 64'd1;
  localparam int N_PHASES = 12;
  localparam int PHASE_ITEMS = 157;
  localparam int SETTLE_CYCLES = 64;

  typedef enum logic [1:0] {ENT_EVENT, ENT_CFG, ENT_DRAIN} entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic        op;
    logic [63:0] stamp;
    logic        idx;
    logic [19:0] data;
    int unsigned gap;
    int unsigned rx_max;
  } tach_entry_t;

  typedef struct {
    logic [23:0] rpm;
    logic [2:0]  status;
  } speed_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [19:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [63:0] in_edge_time_ns = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_rpm_tenths;
  logic [2:0]  out_status;

  tachometer_rolling_rpm_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_edge_time_ns (in_edge_time_ns),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rpm_tenths  (out_rpm_tenths),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the block.
  logic [63:0] ref_stamp;
  bit          ref_held;
  logic [63:0] period_ring [WIN];
  int unsigned n_stored;
  int unsigned slot;
  logic [63:0] period_sum;
  logic [23:0] reading;
  logic [7:0]  ppr;
  logic [19:0] deb_us;

  speed_word_t speed_expect_q[$];
  tach_entry_t entries[$];
  int unsigned n_predicted = 0;
  int unsigned n_checked = 0;
  int unsigned n_fail = 0;
  int unsigned rx_max = 19;

  // Stimulus generator view of the reference time and debounce window.
  logic [63:0] gen_stamp;
  bit          gen_ref;
  logic [63:0] gen_deb_ns;
  int unsigned tx_max;

  function automatic logic [23:0] rpm_from_sum(input logic [63:0] total,
                                               input int unsigned cnt,
                                               input logic [7:0] pulses);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    num = 64'(tach_pkg::TENTHS_NS_PER_MIN) * 64'(cnt);
    if (total == 64'd0 || pulses == 8'd0) return tach_pkg::RPM_MAX;
    if (total > num) return 24'd0;
    den = total * 64'(pulses);
    q = num / den;
    return (q > 64'(tach_pkg::RPM_MAX)) ? tach_pkg::RPM_MAX : q[23:0];
  endfunction

  task automatic predict_event(input logic op, input logic [63:0] stamp);
    logic [63:0] delta;
    logic [63:0] p;
    logic [64:0] acc;
    speed_word_t w;
    if (op == tach_pkg::OP_TIMEOUT) begin
      if (ref_held) begin
        reading = '0;
        n_stored = 0;
        slot = 0;
        period_sum = '0;
        ref_held = 1'b0;
        w.status = tach_pkg::STAT_TIMEOUT_CLR;
      end else begin
        w.status = tach_pkg::STAT_TIMEOUT_IGN;
      end
    end else if (!ref_held) begin
      ref_stamp = stamp;
      ref_held = 1'b1;
      w.status = tach_pkg::STAT_REFERENCE;
    end else begin
      // Backwards timestamps wrap to a huge spacing and then saturate.
      delta = stamp - ref_stamp;
      if (delta < 64'(deb_us) * 64'd1000) begin
        w.status = tach_pkg::STAT_DEBOUNCED;
      end else begin
        p = (delta > PERIOD_CAP) ? PERIOD_CAP : delta;
        period_ring[slot] = p;
        slot = (slot + 1) % WIN;
        if (n_stored < WIN) n_stored++;
        acc = '0;
        for (int i = 0; i < n_stored; i++) begin
          acc = acc + 65'(period_ring[i]);
          if (acc[64]) acc = {1'b0, {64{1'b1}}};
        end
        period_sum = acc[63:0];
        reading = rpm_from_sum(period_sum, n_stored, ppr);
        ref_stamp = stamp;
        w.status = tach_pkg::STAT_UPDATED;
      end
    end
    w.rpm = reading;
    speed_expect_q.push_back(w);
  endtask

  task automatic apply_config(input logic idx, input logic [19:0] data);
    if (idx == tach_pkg::CFG_PULSES_PER_REV) ppr = data[7:0];
    else deb_us = data;
  endtask

  task automatic add_event(input logic op, input logic [63:0] stamp);
    tach_entry_t e;
    e.kind = ENT_EVENT;
    e.op = op;
    e.stamp = stamp;
    e.idx = tach_pkg::CFG_PULSES_PER_REV;
    e.data = '0;
    e.gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
    e.rx_max = 0;
    entries.push_back(e);
    if (op == tach_pkg::OP_TIMEOUT) begin
      gen_ref = 1'b0;
    end else if (!gen_ref) begin
      gen_ref = 1'b1;
      gen_stamp = stamp;
    end else if (stamp - gen_stamp >= gen_deb_ns) begin
      gen_stamp = stamp;
    end
  endtask

  task automatic add_cfg(input logic idx, input logic [19:0] data);
    tach_entry_t e;
    e.kind = ENT_CFG;
    e.op = tach_pkg::OP_EDGE;
    e.stamp = '0;
    e.idx = idx;
    e.data = data;
    e.gap = 0;
    e.rx_max = 0;
    entries.push_back(e);
    if (idx == tach_pkg::CFG_DEBOUNCE_US) gen_deb_ns = 64'(data) * 64'd1000;
  endtask

  task automatic add_drain(input int unsigned rx_limit);
    tach_entry_t e;
    e.kind = ENT_DRAIN;
    e.op = tach_pkg::OP_EDGE;
    e.stamp = '0;
    e.idx = tach_pkg::CFG_PULSES_PER_REV;
    e.data = '0;
    e.gap = 0;
    e.rx_max = rx_limit;
    entries.push_back(e);
  endtask

  // Mostly plausible spacings around the debounce window, with bounces,
  // boundary hits, very long gaps, backwards steps and arbitrary jumps.
  function automatic logic [63:0] next_edge_stamp();
    int unsigned r;
    logic [63:0] sp;
    r = $urandom_range(0, 99);
    if (!gen_ref) return {$urandom, $urandom};
    if (r < 60) sp = gen_deb_ns + 64'($urandom_range(0, 3000000));
    else if (r < 70) sp = (gen_deb_ns == 0) ? 64'd0 :
                          64'($urandom_range(0, 32'(gen_deb_ns - 64'd1)));
    else if (r < 75) sp = gen_deb_ns - 64'($urandom_range(0, 1));
    else if (r < 80) sp = 64'd600000000000 + {24'd0, 8'($urandom_range(0, 255)), $urandom};
    else if (r < 85) sp = -64'($urandom_range(1, 5000000));
    else if (r < 90) sp = {$urandom, $urandom};
    else sp = gen_deb_ns + {30'd0, 2'($urandom_range(0, 3)), $urandom};
    return gen_stamp + sp;
  endfunction

  // Sender: one word at a time from the pending queue.
  int unsigned gap_left;
  bit          armed;
  int unsigned settle;

  always @(posedge clk) begin : drv_proc
    logic fire;
    logic valid_nx;
    logic wr_nx;
    logic quiet;
    tach_entry_t head;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
      gap_left = 0;
      armed = 1'b0;
      settle = 0;
      ppr = tach_pkg::PPR_RESET;
      deb_us = tach_pkg::DEBOUNCE_RESET;
      ref_stamp = '0;
      ref_held = 1'b0;
      n_stored = 0;
      slot = 0;
      period_sum = '0;
      reading = '0;
    end else begin
      fire = in_valid && !in_stall;
      valid_nx = in_valid && in_stall;
      wr_nx = 1'b0;
      quiet = !in_valid && (n_predicted == n_checked);
      if (fire) begin
        predict_event(in_op, in_edge_time_ns);
        n_predicted <= n_predicted + 1;
      end
      if (!valid_nx && entries.size() != 0) begin
        head = entries[0];
        case (head.kind)
          ENT_EVENT: begin
            if (!armed) begin
              gap_left = head.gap;
              armed = 1'b1;
            end
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              valid_nx = 1'b1;
              in_op <= head.op;
              in_edge_time_ns <= head.stamp;
              void'(entries.pop_front());
              armed = 1'b0;
            end
          end
          ENT_DRAIN: begin
            if (quiet) begin
              rx_max <= head.rx_max;
              void'(entries.pop_front());
            end
          end
          default: begin
            // Registers change only once the block has been idle for a while.
            if (!quiet) begin
              settle = 0;
            end else if (settle < SETTLE_CYCLES) begin
              settle++;
            end else begin
              wr_nx = 1'b1;
              cfg_index <= head.idx;
              cfg_wdata <= head.data;
              apply_config(head.idx, head.data);
              void'(entries.pop_front());
              settle = 0;
            end
          end
        endcase
      end
      in_valid <= valid_nx;
      cfg_wr_en <= wr_nx;
    end
  end

  // Receiver: stalls a random number of cycles after each word it takes.
  int unsigned stall_left;

  always @(posedge clk) begin : mon_proc
    speed_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (n_predicted == n_checked) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result word: rpm %0d status %0d", out_rpm_tenths, out_status);
        end else begin
          want = speed_expect_q.pop_front();
          n_checked <= n_checked + 1;
          if (out_rpm_tenths !== want.rpm || out_status !== want.status) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch on word %0d: rpm exp %0d got %0d, status exp %0d got %0d",
                       n_checked, want.rpm, out_rpm_tenths, want.status, out_status);
          end
        end
        stall_left = $urandom_range(0, rx_max);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  initial begin : stim_proc
    int unsigned r;
    logic [63:0] t0;
    logic [19:0] deb_val;
    logic [7:0] ppr_val;
    gen_deb_ns = 64'd1000000;
    gen_ref = 1'b0;
    gen_stamp = '0;
    tx_max = 5;

    // Reset defaults: 1 pulse per revolution, 1 ms debounce.
    add_event(tach_pkg::OP_TIMEOUT, '1);
    add_event(tach_pkg::OP_EDGE, 64'd0);
    add_event(tach_pkg::OP_EDGE, 64'd500000);
    add_event(tach_pkg::OP_EDGE, 64'd999999);
    add_event(tach_pkg::OP_EDGE, 64'd1000000);
    add_event(tach_pkg::OP_EDGE, 64'd2000000);
    add_event(tach_pkg::OP_EDGE, 64'd1500000);
    add_event(tach_pkg::OP_TIMEOUT, 64'd0);
    add_event(tach_pkg::OP_TIMEOUT, 64'd7);
    add_event(tach_pkg::OP_EDGE, '1);
    add_event(tach_pkg::OP_EDGE, 64'd1999999);
    add_event(tach_pkg::OP_EDGE, 64'd1999999 + 64'd700000000000);
    add_event(tach_pkg::OP_EDGE,
              64'd1999999 + 64'd700000000000 + (64'd1 << PBITS) + 64'd5);

    // No debounce and the most pulses; a zero spacing leaves a zero sum.
    add_drain(19);
    add_cfg(tach_pkg::CFG_PULSES_PER_REV, 20'hFFFFF);
    add_cfg(tach_pkg::CFG_DEBOUNCE_US, 20'd0);
    t0 = 64'h8000_0000_0000_0000;
    add_event(tach_pkg::OP_TIMEOUT, 64'd0);
    add_event(tach_pkg::OP_EDGE, t0);
    add_event(tach_pkg::OP_EDGE, t0);
    add_event(tach_pkg::OP_EDGE, t0 + 64'd10);

    // Zero pulses per revolution saturates the reading.
    add_drain(19);
    add_cfg(tach_pkg::CFG_PULSES_PER_REV, 20'h00F00);
    add_event(tach_pkg::OP_EDGE, t0 + 64'd1000010);
    add_event(tach_pkg::OP_TIMEOUT, 64'd0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      add_drain((ph % 3 == 0) ? 0 : 19);
      case (ph)
        2: deb_val = 20'd0;
        3: deb_val = 20'd1000000;
        4: deb_val = 20'hFFFFF;
        default: deb_val = ($urandom_range(0, 1) == 0) ? 20'($urandom_range(0, 2000)) :
                                                          20'($urandom_range(0, 1000000));
      endcase
      add_cfg(tach_pkg::CFG_DEBOUNCE_US, deb_val);
      if (ph % 3 != 2) begin
        case (ph % 4)
          0: ppr_val = 8'd1;
          1: ppr_val = 8'd255;
          default: ppr_val = 8'($urandom_range(1, 255));
        endcase
        if (ph == 5) ppr_val = 8'd0;
        add_cfg(tach_pkg::CFG_PULSES_PER_REV, {12'($urandom_range(0, 4095)), ppr_val});
      end
      tx_max = (ph % 4 == 1) ? 0 : 19;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          add_event(tach_pkg::OP_TIMEOUT, {$urandom, $urandom});
          if ($urandom_range(0, 9) < 3) add_event(tach_pkg::OP_TIMEOUT, {$urandom, $urandom});
        end else begin
          add_event(tach_pkg::OP_EDGE, next_edge_stamp());
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Sampled on the falling edge so that every clocked update has settled.
    @(negedge clk);
    while (entries.size() != 0 || in_valid || n_predicted != n_checked) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0 && n_predicted == n_checked) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #10000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### tachometer_rolling_rpm_unit.f
hdl/tach_pkg.sv
hdl/tach_ctrl.sv
hdl/tach_dp.sv
hdl/tachometer_rolling_rpm_unit.sv
hdl/tach_chk.sv
tb/tb_tachometer_rolling_rpm_unit.sv
